>>> rtl/lif_pkg.sv
// Shared types and constants for the leaky integrate-and-fire neuron block.
package lif_pkg;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;
    localparam int CFG_IDX_W = 3;

    localparam logic OPC_UPDATE  = 1'b0;
    localparam logic OPC_RECEIVE = 1'b1;

    typedef enum logic [1:0] {
        KIND_UPDATE  = 2'd0,
        KIND_RECEIVE = 2'd1,
        KIND_REPORT  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY     = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_CURRENT   = 3'd2,
        CFG_THRESHOLD = 3'd3,
        CFG_RESET_POT = 3'd4,
        CFG_WEIGHT    = 3'd5,
        CFG_REFRACT   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        kind_t              kind;
        logic [9:0]         steps;
        logic [7:0]         poisson;
        logic signed [31:0] amplitude;
        logic [3:0]         delay;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic               spiked;
        logic signed [31:0] potential;
        logic [15:0]        spike_count;
        logic [31:0]        last_spike_time;
    } result_t;

endpackage

>>> rtl/lif_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lif_front.sv
// Input side: accepts stream words, classifies them and queues them for the core.
module lif_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lif_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output lif_pkg::queue_head_t           head,
    input  logic                           pop
);
    import lif_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    item_t      incoming;
    logic       push;
    logic       do_pop;

    always_comb
    begin
        incoming.steps     = s_tdata[9:0];
        incoming.poisson   = s_tdata[17:10];
        incoming.amplitude = $signed(s_tdata[49:18]);
        incoming.delay     = s_tdata[53:50];
        priority if (s_tuser == OPC_RECEIVE)
        begin
            incoming.kind = KIND_RECEIVE;
        end
        else if (s_tdata[9:0] == 10'd0)
        begin
            incoming.kind = KIND_REPORT;
        end
        else
        begin
            incoming.kind = KIND_UPDATE;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

>>> rtl/lif_core.sv
// Execution side: neuron state, delay ring, configuration registers and result register.
module lif_core #(
    parameter int DELAY_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lif_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    input  lif_pkg::queue_head_t            head,
    output logic                            pop,
    output logic                            res_valid,
    input  logic                            res_ready,
    output lif_pkg::result_t                res
);
    import lif_pkg::*;

    localparam int IDXW = $clog2(DELAY_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_CALC  = 6'b000100,
        ST_RX_RD = 6'b001000,
        ST_RX_WR = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [16:0]             decay_reg, decay_next;
    logic [30:0]             gain_reg, gain_next;
    logic signed [31:0]      current_reg, current_next;
    logic signed [31:0]      threshold_reg, threshold_next;
    logic signed [31:0]      reset_pot_reg, reset_pot_next;
    logic signed [31:0]      weight_reg, weight_next;
    logic [9:0]              refract_reg, refract_next;

    logic signed [31:0]      membrane_reg, membrane_next;
    logic [31:0]             clock_reg, clock_next;
    logic [31:0]             latest_reg, latest_next;
    logic [15:0]             total_reg, total_next;
    logic                    ever_reg, ever_next;
    logic                    refr_flag_reg, refr_flag_next;
    logic [IDXW-1:0]         idx_reg, idx_next;
    logic [DELAY_DEPTH-1:0]  slot_valid_reg, slot_valid_next;
    logic [9:0]              steps_left_reg, steps_left_next;
    logic                    spiked_reg, spiked_next;
    logic                    out_valid_reg, out_valid_next;

    item_t                   item_reg;
    result_t                 out_reg;
    logic signed [49:0]      dprod_reg;
    logic signed [63:0]      gprod_reg;
    logic signed [40:0]      pprod_reg;
    logic [IDXW-1:0]         wr_idx_reg;

    logic [IDXW-1:0]         dmod_tab [16];
    logic [32:0]             rx_sum;
    logic [IDXW:0]           rx_wide;
    logic [IDXW-1:0]         rx_idx;
    logic [IDXW-1:0]         ram_raddr;
    logic [31:0]             ram_rdata;
    logic                    ram_we;
    logic signed [31:0]      ram_wdata;
    logic signed [31:0]      slot_val;
    logic signed [31:0]      rx_slot_val;
    logic signed [32:0]      rx_acc;
    logic signed [49:0]      step_sum;
    logic signed [31:0]      step_sat;
    logic                    spike_now;
    logic [31:0]             latest_cand;
    logic                    ever_cand;
    logic                    out_free;

    for (genvar g = 0; g < 16; g++)
    begin : g_dmod
        assign dmod_tab[g] = IDXW'(g % DELAY_DEPTH);
    end

    assign rx_sum  = {1'b0, clock_reg} + 33'(item_reg.delay);
    assign rx_wide = {1'b0, idx_reg} + {1'b0, dmod_tab[item_reg.delay]};

    always_comb
    begin
        if (rx_sum[32])
        begin
            rx_idx = dmod_tab[rx_sum[3:0]];
        end
        else if (rx_wide >= (IDXW+1)'(DELAY_DEPTH))
        begin
            rx_idx = IDXW'(rx_wide - (IDXW+1)'(DELAY_DEPTH));
        end
        else
        begin
            rx_idx = rx_wide[IDXW-1:0];
        end
    end

    assign ram_raddr   = (state_reg == ST_RX_RD) ? rx_idx : idx_reg;
    assign slot_val    = slot_valid_reg[idx_reg] ? $signed(ram_rdata) : 32'sd0;
    assign rx_slot_val = slot_valid_reg[wr_idx_reg] ? $signed(ram_rdata) : 32'sd0;
    assign rx_acc      = 33'(rx_slot_val) + 33'(item_reg.amplitude);
    assign ram_we      = (state_reg == ST_RX_WR);

    always_comb
    begin
        if (rx_acc > 33'sd2147483647)
        begin
            ram_wdata = 32'sh7FFFFFFF;
        end
        else if (rx_acc < -33'sd2147483648)
        begin
            ram_wdata = 32'sh80000000;
        end
        else
        begin
            ram_wdata = rx_acc[31:0];
        end
    end

    lif_ram #(
        .WIDTH (32),
        .DEPTH (DELAY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign step_sum = 50'(dprod_reg >>> 16) + 50'(gprod_reg >>> 16)
                    + 50'(slot_val) + 50'(pprod_reg);

    always_comb
    begin
        if (step_sum > 50'sd2147483647)
        begin
            step_sat = 32'sh7FFFFFFF;
        end
        else if (step_sum < -50'sd2147483648)
        begin
            step_sat = 32'sh80000000;
        end
        else
        begin
            step_sat = step_sum[31:0];
        end
    end

    assign spike_now   = (membrane_reg >= threshold_reg);
    assign latest_cand = spike_now ? clock_reg : latest_reg;
    assign ever_cand   = ever_reg || spike_now;
    assign out_free    = !out_valid_reg || res_ready;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        decay_next      = decay_reg;
        gain_next       = gain_reg;
        current_next    = current_reg;
        threshold_next  = threshold_reg;
        reset_pot_next  = reset_pot_reg;
        weight_next     = weight_reg;
        refract_next    = refract_reg;
        membrane_next   = membrane_reg;
        clock_next      = clock_reg;
        latest_next     = latest_reg;
        total_next      = total_reg;
        ever_next       = ever_reg;
        refr_flag_next  = refr_flag_reg;
        idx_next        = idx_reg;
        slot_valid_next = slot_valid_reg;
        steps_left_next = steps_left_reg;
        spiked_next     = spiked_reg;
        out_valid_next  = out_valid_reg;
        pop             = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DECAY:     decay_next     = cfg_data[16:0];
                CFG_GAIN:      gain_next      = cfg_data[30:0];
                CFG_CURRENT:   current_next   = $signed(cfg_data);
                CFG_THRESHOLD: threshold_next = $signed(cfg_data);
                CFG_RESET_POT: reset_pot_next = $signed(cfg_data);
                CFG_WEIGHT:    weight_next    = $signed(cfg_data);
                CFG_REFRACT:   refract_next   = cfg_data[9:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop             = 1'b1;
                    spiked_next     = 1'b0;
                    steps_left_next = head.item.steps;
                    unique case (head.item.kind)
                        KIND_UPDATE:  state_next = ST_READ;
                        KIND_RECEIVE: state_next = ST_RX_RD;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:
            begin
                latest_next = latest_cand;
                ever_next   = ever_cand;
                if (spike_now)
                begin
                    spiked_next = 1'b1;
                    if (total_reg != 16'hFFFF)
                    begin
                        total_next = total_reg + 16'd1;
                    end
                end
                if (ever_cand)
                begin
                    refr_flag_next = (clock_reg - latest_cand) < {22'd0, refract_reg};
                end
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                membrane_next            = refr_flag_reg ? reset_pot_reg : step_sat;
                slot_valid_next[idx_reg] = 1'b0;
                clock_next               = clock_reg + 32'd1;
                if (clock_reg == 32'hFFFFFFFF || idx_reg == IDXW'(DELAY_DEPTH - 1))
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDXW'(1);
                end
                steps_left_next = steps_left_reg - 10'd1;
                state_next      = (steps_left_reg == 10'd1) ? ST_DONE : ST_READ;
            end
            ST_RX_RD:
            begin
                state_next = ST_RX_WR;
            end
            ST_RX_WR:
            begin
                slot_valid_next[wr_idx_reg] = 1'b1;
                state_next                  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            decay_reg      <= 17'd65209;
            gain_reg       <= 31'd6540;
            current_reg    <= 32'sd0;
            threshold_reg  <= 32'sd1310720;
            reset_pot_reg  <= 32'sd0;
            weight_reg     <= 32'sd6554;
            refract_reg    <= 10'd20;
            membrane_reg   <= 32'sd0;
            clock_reg      <= 32'd0;
            latest_reg     <= 32'd0;
            total_reg      <= 16'd0;
            ever_reg       <= 1'b0;
            refr_flag_reg  <= 1'b0;
            idx_reg        <= '0;
            slot_valid_reg <= '0;
            steps_left_reg <= 10'd0;
            spiked_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            decay_reg      <= decay_next;
            gain_reg       <= gain_next;
            current_reg    <= current_next;
            threshold_reg  <= threshold_next;
            reset_pot_reg  <= reset_pot_next;
            weight_reg     <= weight_next;
            refract_reg    <= refract_next;
            membrane_reg   <= membrane_next;
            clock_reg      <= clock_next;
            latest_reg     <= latest_next;
            total_reg      <= total_next;
            ever_reg       <= ever_next;
            refr_flag_reg  <= refr_flag_next;
            idx_reg        <= idx_next;
            slot_valid_reg <= slot_valid_next;
            steps_left_reg <= steps_left_next;
            spiked_reg     <= spiked_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && head.valid)
        begin
            item_reg <= head.item;
        end
        if (state_reg == ST_READ)
        begin
            dprod_reg <= membrane_reg * $signed({1'b0, decay_reg});
            gprod_reg <= $signed({1'b0, gain_reg}) * current_reg;
            pprod_reg <= $signed({1'b0, item_reg.poisson}) * weight_reg;
        end
        if (state_reg == ST_RX_RD)
        begin
            wr_idx_reg <= rx_idx;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg.spiked          <= spiked_reg;
            out_reg.potential       <= membrane_reg;
            out_reg.spike_count     <= total_reg;
            out_reg.last_spike_time <= latest_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> rtl/lif_neuron_with_delay_ring.sv
// Top level of the leaky integrate-and-fire neuron with a delay ring.
//
// Input words arrive on the s_ stream: s_tuser selects an update (0) or a
// receive (1). An update runs the given number of time steps; a receive adds
// an amplitude into the ring slot that lies the given delay ahead of the
// step clock. Every input word produces exactly one result word on the m_
// stream, carrying the spike flag, potential, spike count and last spike time.
// Configuration registers are written through the cfg_ channel, which is
// always ready; writes are meant for times when no word is in flight.
// An update runs a dispatch state, then per step a ring read and product state
// and a sum and writeback state, then a result load state; a receive runs a
// dispatch, a ring read, a ring write and the result load, and a zero-step
// update goes from dispatch straight to the result load. One word is worked
// on at a time: the next queued word is taken only after the result load of
// the word before it.
// A two-entry queue takes input words while the core is busy, and a result
// register holds a word while the receiver stalls; the core waits on a full
// result register and the queue then fills and drops s_tready.
// Reset clears all neuron state, the ring valid bits and the queues, and
// loads the configuration registers with their default values.
module lif_neuron_with_delay_ring #(
    parameter int DELAY_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // steps[9:0], poisson[17:10], amplitude[49:18], delay[53:50], zero fill
    input  logic [lif_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // spiked[0], potential[32:1], spike_count[48:33], last_spike_time[80:49], zero fill
    output logic [lif_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);
    import lif_pkg::*;

    queue_head_t head;
    logic        pop;
    result_t     res;

    lif_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    lif_core #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'd0, res.last_spike_time, res.spike_count, res.potential, res.spiked};

endmodule

>>> rtl/lif_chk.sv
// Port-level checker for the neuron block, bound to the top level.
module lif_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lif_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lif_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [lif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [31:0]                    cfg_data
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result word dropped while stalled.");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Result word changed while stalled.");

    a_spike_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[48:33] != 16'd0)
        else $error("Spike reported with a zero spike count.");

    a_no_spike_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[48:33] == 16'd0 |-> m_tdata[80:49] == 32'd0)
        else $error("Last spike time set before any spike.");

endmodule

bind lif_neuron_with_delay_ring lif_chk u_lif_chk (.*);
